/* design/ufr_pkg.sv */
`default_nettype none

package ufr_pkg;

   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] WRITE_FLAG  = 8'h80;
   localparam logic [7:0] SYNC_RESET  = 8'h05;
   localparam logic [7:0] NODE_RESET  = 8'h00;

   localparam int         FRAME_BYTES = 7;
   localparam int         FRAME_WIDTH = 8 * FRAME_BYTES;

   localparam logic [2:0] LAST_WRITE  = 3'd7;
   localparam logic [2:0] LAST_READ   = 3'd3;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_NODE_ADDRESS = 1'b0,
      REG_SYNC_BYTE    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] node_address;
      logic [7:0] sync_byte;
   } cfg_type;

   // One byte through the CRC-8 register, least significant bit first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int b = 0; b < 8; b++) begin
         fb = c[7] ^ data[b];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* design/ufr_csr.sv */
`default_nettype none

module ufr_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           psel,
   input  wire logic           penable,
   input  wire logic           pwrite,
   input  wire logic [2:0]     paddr,
   input  wire logic [31:0]    pwdata,
   output logic      [31:0]    prdata,
   output logic                pready,
   output ufr_pkg::cfg_type    cfg
);
   import ufr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_NODE_ADDRESS: cfg_in.node_address = pwdata[7:0];
            REG_SYNC_BYTE:    cfg_in.sync_byte    = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_NODE_ADDRESS: prdata = {24'd0, cfg_ff.node_address};
         REG_SYNC_BYTE:    prdata = {24'd0, cfg_ff.sync_byte};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_address <= NODE_RESET;
         cfg_ff.sync_byte    <= SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/ufr_framer.sv */
`default_nettype none

module ufr_framer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ufr_pkg::cfg_type cfg,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_operation,
   input  wire logic [6:0]       req_reg_address,
   input  wire logic [31:0]      req_write_data,
   output logic                  rsp_strobe,
   output logic      [7:0]       rsp_tx_byte,
   output logic                  rsp_last_byte
);
   import ufr_pkg::*;

   logic                   active_ff, active_in;
   logic                   read_ff, read_in;
   logic [2:0]             idx_ff, idx_in;
   logic [7:0]             crc_ff, crc_in;
   logic [FRAME_WIDTH-1:0] frame_ff, frame_in;
   logic                   strobe_ff, strobe_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;

   logic                   accept;
   logic                   at_last;
   logic [2:0]             last_idx;
   logic [7:0]             cur_byte;
   logic [7:0]             addr_byte;
   logic                   is_read;

   assign last_idx  = read_ff ? LAST_READ : LAST_WRITE;
   assign at_last   = active_ff && (idx_ff == last_idx);
   assign busy      = active_ff && !at_last;
   assign accept    = start && !busy;
   assign cur_byte  = at_last ? crc_ff : frame_ff[FRAME_WIDTH-1 -: 8];
   assign is_read   = (op_type'(req_operation) == OP_READ);
   assign addr_byte = is_read ? {1'b0, req_reg_address}
                              : ({1'b0, req_reg_address} | WRITE_FLAG);

   always_comb begin
      active_in = active_ff;
      read_in   = read_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      frame_in  = frame_ff;
      strobe_in = 1'b0;
      byte_in   = byte_ff;
      last_in   = last_ff;

      if (active_ff) begin
         strobe_in = 1'b1;
         byte_in   = cur_byte;
         last_in   = at_last;
         crc_in    = crc8_step(crc_ff, cur_byte);
         frame_in  = {frame_ff[FRAME_WIDTH-9:0], 8'd0};
         idx_in    = 3'(idx_ff + 3'd1);
         if (at_last) begin
            active_in = 1'b0;
         end
      end

      if (accept) begin
         active_in = 1'b1;
         read_in   = is_read;
         idx_in    = 3'd0;
         crc_in    = 8'd0;
         frame_in  = {cfg.sync_byte, cfg.node_address, addr_byte, req_write_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      read_ff  <= read_in;
      idx_ff   <= idx_in;
      crc_ff   <= crc_in;
      frame_ff <= frame_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

`default_nettype wire

/* design/uart_register_datagram_framer.sv */
`default_nettype none

// Builds single-wire UART register datagrams, one word per cycle on rsp_tx_byte
// with rsp_strobe high. A write request gives eight words and a read request four,
// the last being the CRC-8 with rsp_last_byte set. Once start is taken the request
// is loaded into frame_ff, and each word passes through the output register byte_ff.
// busy drops on the cycle that carries the word just before the CRC word, so a new
// request can be taken then and its words follow the CRC word without a gap. The
// receiver cannot stall; every strobed word must be taken in its cycle. Registers
// should be written only while the block is idle.
module uart_register_datagram_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [6:0]  req_reg_address,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_strobe,
   output logic      [7:0]  rsp_tx_byte,
   output logic             rsp_last_byte,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import ufr_pkg::*;

   cfg_type cfg;

   ufr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ufr_framer u_framer (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_reg_address (req_reg_address),
      .req_write_data  (req_write_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

`default_nettype wire

/* sim/uart_register_datagram_framer_tb.sv */
module uart_register_datagram_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufr_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } dgram_word_type;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        start           = 1'b0;
   op_type      req_operation   = OP_WRITE;
   logic [6:0]  req_reg_address = '0;
   logic [31:0] req_write_data  = '0;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [2:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;

   wire         busy;
   wire         rsp_strobe;
   wire  [7:0]  rsp_tx_byte;
   wire         rsp_last_byte;
   wire  [31:0] prdata;
   wire         pready;

   cfg_type        framer_cfg = '{node_address: NODE_RESET, sync_byte: SYNC_RESET};
   dgram_word_type datagram_words[$];
   int             mismatches  = 0;
   int             cycle_count = 0;
   bit             steady_sender = 1'b0;

   uart_register_datagram_framer uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_reg_address(req_reg_address),
      .req_write_data(req_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last_byte(rsp_last_byte),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [7:0] crc8_lsb_first(logic [7:0] crc, logic [7:0] value);
      logic feedback;
      for (int i = 0; i < 8; i++) begin
         feedback = crc[7] ^ value[i];
         crc      = (crc << 1) ^ (feedback ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   function automatic void predict_datagram(op_type op, logic [6:0] addr, logic [31:0] data);
      logic [7:0] frame [8];
      logic [7:0] crc;
      int         len;
      frame[0] = framer_cfg.sync_byte;
      frame[1] = framer_cfg.node_address;
      if (op == OP_READ) begin
         frame[2] = {1'b0, addr};
         len      = 4;
      end else begin
         frame[2] = WRITE_FLAG | {1'b0, addr};
         frame[3] = data[31:24];
         frame[4] = data[23:16];
         frame[5] = data[15:8];
         frame[6] = data[7:0];
         len      = 8;
      end
      crc = 8'h00;
      for (int k = 0; k < len - 1; k++) begin
         crc = crc8_lsb_first(crc, frame[k]);
      end
      frame[len - 1] = crc;
      for (int k = 0; k < len; k++) begin
         datagram_words.push_back('{tx_byte: frame[k], last_byte: (k == len - 1)});
      end
   endfunction

   function automatic int random_gap();
      int pick;
      if (steady_sender) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(op_type op, logic [6:0] addr, logic [31:0] data);
      int gap;
      start           <= 1'b1;
      req_operation   <= op;
      req_reg_address <= addr;
      req_write_data  <= data;
      do @(posedge clock); while (busy);
      predict_datagram(op, addr, data);
      gap = random_gap();
      if (gap > 0) begin
         start           <= 1'b0;
         req_operation   <= op_type'($urandom_range(0, 1));
         req_reg_address <= 7'($urandom);
         req_write_data  <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (datagram_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_NODE_ADDRESS: begin
            framer_cfg.node_address = value[7:0];
         end
         REG_SYNC_BYTE: begin
            framer_cfg.sync_byte = value[7:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'd0, value[7:0]}) begin
         $error("prdata: expected %h, got %h", {24'd0, value[7:0]}, prdata);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      dgram_word_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (datagram_words.size() == 0) begin
            $error("unexpected word: tx_byte %h last_byte %b", rsp_tx_byte, rsp_last_byte);
            mismatches++;
         end else begin
            want = datagram_words.pop_front();
            if (rsp_tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_tx_byte);
               mismatches++;
            end
            if (rsp_last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_last_byte);
               mismatches++;
            end
         end
      end
   end

   task automatic test_reset_values();
      send_request(OP_WRITE, 7'h00, 32'h12345678);
      send_request(OP_READ, 7'h7F, 32'h00000000);
      settle();
   endtask

   task automatic test_field_extremes();
      send_request(OP_WRITE, 7'h00, 32'h00000000);
      send_request(OP_WRITE, 7'h7F, 32'hFFFFFFFF);
      send_request(OP_WRITE, 7'h55, 32'hAAAAAAAA);
      send_request(OP_WRITE, 7'h2A, 32'h55555555);
      send_request(OP_READ, 7'h00, 32'hFFFFFFFF);
      send_request(OP_READ, 7'h7F, 32'h00000000);
      send_request(OP_READ, 7'h2A, 32'hDEADBEEF);
      settle();
   endtask

   task automatic test_register_extremes();
      write_register(REG_NODE_ADDRESS, 32'hFFFFFFFF);
      write_register(REG_SYNC_BYTE, 32'hFFFFFFFF);
      send_request(OP_WRITE, 7'h11, 32'h01020304);
      send_request(OP_READ, 7'h22, 32'h80000001);
      settle();
      write_register(REG_NODE_ADDRESS, 32'hABCDEF00);
      write_register(REG_SYNC_BYTE, 32'h12345600);
      send_request(OP_WRITE, 7'h00, 32'h00000000);
      send_request(OP_READ, 7'h00, 32'h00000000);
      settle();
      write_register(REG_NODE_ADDRESS, 32'h00000080);
      write_register(REG_SYNC_BYTE, 32'hFFFFFF01);
      send_request(OP_WRITE, 7'h40, 32'hF00FF00F);
      send_request(OP_READ, 7'h01, 32'h0FF00FF0);
      settle();
   endtask

   task automatic test_back_to_back();
      steady_sender = 1'b1;
      for (int i = 0; i < 6; i++) begin
         send_request((i % 2) ? OP_READ : OP_WRITE, 7'($urandom), $urandom);
      end
      steady_sender = 1'b0;
      settle();
   endtask

   task automatic test_random_traffic();
      logic [31:0] data;
      int          pick;
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            1: begin
               write_register(REG_NODE_ADDRESS, 32'h000000FF);
               write_register(REG_SYNC_BYTE, 32'h00000000);
            end
            3: begin
               write_register(REG_NODE_ADDRESS, 32'h00000000);
               write_register(REG_SYNC_BYTE, 32'h000000FF);
            end
            default: begin
               write_register(REG_NODE_ADDRESS, $urandom);
               write_register(REG_SYNC_BYTE, $urandom);
            end
         endcase
         steady_sender = (phase == 2);
         for (int i = 0; i < 30; i++) begin
            pick = $urandom_range(0, 9);
            data = (pick == 0) ? 32'h00000000 : (pick == 1) ? 32'hFFFFFFFF : $urandom;
            send_request(op_type'($urandom_range(0, 1)), 7'($urandom), data);
         end
         steady_sender = 1'b0;
      end
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_extremes();
      test_register_extremes();
      test_back_to_back();
      test_random_traffic();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
